// ===== rtl/cbr_pkg.sv =====
// Shared types and constants for the streaming convolution block.
// Used by cbr_ctrl, cbr_dp and conv2d_bias_relu_stream; depends on nothing.
package cbr_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic       CFG_FRAC_SHIFT  = 1'b0;
    localparam logic       CFG_RELU_ENABLE = 1'b1;
    localparam logic [3:0] FRAC_SHIFT_RST  = 4'd8;
    localparam logic       RELU_ENABLE_RST = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // an input item is accepted this cycle
        logic cap;    // the item is a pixel: hold it and read the line store
        logic shift;  // shift the window, update the line store and position
        logic issue;  // start one multiply of the current tap
        logic emit;   // finish the current filter into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_full;     // the current position completes a full window
        logic tap_last;     // the tap being issued is the last of the kernel
        logic filter_last;  // the filter being finished is the last one
        logic pipe_busy;    // products are still in flight
        logic out_free;     // the output register can take a result
    } stat_t;

endpackage

// ===== rtl/cbr_ctrl.sv =====
// Controller state machine for the streaming convolution block.
// Depends on cbr_pkg for the command and status structs.
module cbr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         kind,
    input  cbr_pkg::stat_t     stat,
    output logic               in_stall,
    output cbr_pkg::cmd_t      cmd
);
    import cbr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && (kind == KIND_PIXEL))
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = stat.win_full ? S_MAC : S_IDLE;
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.filter_last ? S_IDLE : S_MAC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is only finished into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> stat.out_free)
        else $error("emit into a busy output register");

    // A filter is finished only once all its products have been summed.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> !stat.pipe_busy)
        else $error("emit with products in flight");

    // The window shifts only right after a pixel was captured.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.shift |-> $past(cmd.cap))
        else $error("shift without a captured pixel");

    // The last filter of a pixel returns the block to accepting items.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.filter_last) |=> !in_stall)
        else $error("block did not return to idle after the last filter");

endmodule

// ===== rtl/cbr_dp.sv =====
// Datapath of the streaming convolution block: filter store, line store,
// window, multiply-accumulate pipeline and output register. Depends on cbr_pkg.
module cbr_dp #(
    parameter int IN_DIM      = 28,
    parameter int FILTER_DIM  = 5,
    parameter int NUM_FILTERS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cbr_pkg::cmd_t       cmd,
    output cbr_pkg::stat_t      stat,
    input  logic [1:0]          kind,
    input  logic [7:0]          index,
    input  logic signed [15:0]  value,
    input  logic [3:0]          frac_shift,
    input  logic                relu_enable,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  result,
    output logic [2:0]          filter_num,
    output logic [4:0]          out_row,
    output logic [4:0]          out_col,
    output logic                last
);
    import cbr_pkg::*;

    localparam int K2       = FILTER_DIM * FILTER_DIM;
    localparam int NWEIGHTS = NUM_FILTERS * K2;
    localparam int COL_W    = $clog2(IN_DIM);
    localparam int TAP_W    = $clog2(K2);
    localparam int WADDR_W  = $clog2(NWEIGHTS);
    localparam int FILT_W   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int ACC_W    = 33 + $clog2(K2);
    localparam int LINES    = FILTER_DIM - 1;

    localparam logic [COL_W-1:0] POS_MAX  = COL_W'(IN_DIM - 1);
    localparam logic [COL_W-1:0] POS_FULL = COL_W'(FILTER_DIM - 1);
    localparam logic [TAP_W-1:0] TAP_MAX  = TAP_W'(K2 - 1);
    localparam logic [FILT_W-1:0] FILT_MAX = FILT_W'(NUM_FILTERS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(64'sd2147483648));

    // Filter store.
    logic signed [15:0] wmem [NWEIGHTS];
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] bias_reg [NUM_FILTERS];
    logic               w_we;
    logic               b_we;

    // Line store, window and pixel position.
    logic signed [15:0] line_rd_reg [LINES];
    logic signed [15:0] win_reg [K2];
    logic signed [15:0] pix_reg;
    logic [COL_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   orow_reg;
    logic [COL_W-1:0]   ocol_reg;

    // Multiply-accumulate pipeline and counters.
    logic [TAP_W-1:0]   tap_reg;
    logic [WADDR_W-1:0] waddr_reg;
    logic [FILT_W-1:0]  filt_reg;
    logic signed [15:0] x_reg;
    logic               v1_reg;
    logic signed [31:0] prod_reg;
    logic               v2_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] biased;
    logic signed [31:0]      final_val;

    assign w_we = cmd.take && (kind == KIND_WEIGHT) && ({24'd0, index} < 32'(NWEIGHTS));
    assign b_we = cmd.take && (kind == KIND_BIAS) && ({24'd0, index} < 32'(NUM_FILTERS));

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[WADDR_W'(index)] <= value;
        end
        if (cmd.issue)
        begin
            w_rd_reg <= wmem[waddr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bias_reg[FILT_W'(index)] <= value;
        end
    end

    // Each line is a memory read and written at the current column.
    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        logic signed [15:0] lmem [IN_DIM];
        always_ff @(posedge clk)
        begin
            if (cmd.cap)
            begin
                line_rd_reg[g] <= lmem[col_reg];
            end
            if (cmd.shift)
            begin
                if (g == LINES - 1)
                begin
                    lmem[col_reg] <= pix_reg;
                end
                else
                begin
                    lmem[col_reg] <= line_rd_reg[(g + 1) % LINES];
                end
            end
        end
    end

    // Window shifts left and takes the new column on the right.
    for (genvar r = 0; r < FILTER_DIM; r++)
    begin : g_win_row
        for (genvar c = 0; c < FILTER_DIM; c++)
        begin : g_win_col
            always_ff @(posedge clk)
            begin
                if (cmd.shift)
                begin
                    if (c < FILTER_DIM - 1)
                    begin
                        win_reg[r * FILTER_DIM + c] <=
                            win_reg[(r * FILTER_DIM + c + 1) % K2];
                    end
                    else if (r < FILTER_DIM - 1)
                    begin
                        win_reg[r * FILTER_DIM + c] <= line_rd_reg[r % LINES];
                    end
                    else
                    begin
                        win_reg[r * FILTER_DIM + c] <= pix_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            pix_reg <= value;
        end
        if (cmd.shift)
        begin
            orow_reg <= row_reg - POS_FULL;
            ocol_reg <= col_reg - POS_FULL;
        end
        if (cmd.issue)
        begin
            x_reg <= win_reg[tap_reg];
        end
        prod_reg <= x_reg * w_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            tap_reg   <= '0;
            waddr_reg <= '0;
            filt_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            acc_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.shift)
            begin
                if (col_reg == POS_MAX)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == POS_MAX) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
                tap_reg   <= '0;
                waddr_reg <= '0;
                filt_reg  <= '0;
                acc_reg   <= '0;
            end
            else if (cmd.emit)
            begin
                acc_reg  <= '0;
                filt_reg <= filt_reg + 1'b1;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (cmd.issue)
            begin
                tap_reg   <= (tap_reg == TAP_MAX) ? '0 : tap_reg + 1'b1;
                waddr_reg <= waddr_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Scale, add bias, clamp and saturate the finished sum.
    always_comb
    begin
        scaled = acc_reg >>> frac_shift;
        biased = scaled + ACC_W'(bias_reg[filt_reg]);
        if (relu_enable && biased[ACC_W-1])
        begin
            final_val = '0;
        end
        else if (biased > SAT_MAX)
        begin
            final_val = 32'sh7fffffff;
        end
        else if (biased < SAT_MIN)
        begin
            final_val = 32'sh80000000;
        end
        else
        begin
            final_val = biased[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result     <= final_val;
            filter_num <= 3'(filt_reg);
            out_row    <= 5'(orow_reg);
            out_col    <= 5'(ocol_reg);
            last       <= (filt_reg == FILT_MAX);
        end
    end

    assign stat.win_full    = (row_reg >= POS_FULL) && (col_reg >= POS_FULL);
    assign stat.tap_last    = (tap_reg == TAP_MAX);
    assign stat.filter_last = (filt_reg == FILT_MAX);
    assign stat.pipe_busy   = v1_reg || v2_reg;
    assign stat.out_free    = !out_valid || !out_stall;

endmodule

// ===== rtl/conv2d_bias_relu_stream.sv =====
// Top level of the streaming 2D convolution with bias and ReLU.
// Depends on cbr_pkg, cbr_ctrl and cbr_dp.
//
//   Port group   Direction  Handshake            Payload
//   input item   in         in_valid / in_stall  kind, index, value
//   result item  out        out_valid / out_stall result, filter_num, out_row, out_col, last
//   config       in         cfg_we               cfg_addr, cfg_wdata
//
// A load item is taken while the block is idle. A pixel that does not
// complete a window is accepted and then shifts the window and the line store.
// A pixel that completes a window then also runs, per filter, the K tap issues
// on the single multiplier, K = FILTER_DIM * FILTER_DIM, a drain of its
// pipeline and an emit that waits for a free output register.
// Reset is asynchronous and active low; it clears the position, the
// configuration registers and all control state, not the stores.
// A stalled result holds in the output register and the next filter waits.
module conv2d_bias_relu_stream #(
    parameter int IN_DIM      = 28,
    parameter int FILTER_DIM  = 5,
    parameter int NUM_FILTERS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [7:0]          index,
    input  logic signed [15:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  result,
    output logic [2:0]          filter_num,
    output logic [4:0]          out_row,
    output logic [4:0]          out_col,
    output logic                last,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [3:0]          cfg_wdata
);
    import cbr_pkg::*;

    cmd_t       cmd;
    stat_t      stat;
    logic [3:0] frac_shift_reg;
    logic       relu_enable_reg;

    // Configuration registers; writes must come only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_shift_reg  <= FRAC_SHIFT_RST;
            relu_enable_reg <= RELU_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAC_SHIFT:  frac_shift_reg  <= cfg_wdata;
                CFG_RELU_ENABLE: relu_enable_reg <= cfg_wdata[0];
                default:         frac_shift_reg  <= frac_shift_reg;
            endcase
        end
    end

    // The controller sequences each pixel through shift and, when it completes a window, taps and emit.
    cbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // The datapath holds the stores, the window and the accumulator.
    cbr_dp #(
        .IN_DIM      (IN_DIM),
        .FILTER_DIM  (FILTER_DIM),
        .NUM_FILTERS (NUM_FILTERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .index       (index),
        .value       (value),
        .frac_shift  (frac_shift_reg),
        .relu_enable (relu_enable_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .filter_num  (filter_num),
        .out_row     (out_row),
        .out_col     (out_col),
        .last        (last)
    );

endmodule

// ===== tb/sv/conv2d_bias_relu_stream_tb.sv =====
// Self-checking testbench for the streaming convolution with bias and ReLU.
// Holds its own scoreboard class and drives the block through plain tasks.
// Depends on cbr_pkg and conv2d_bias_relu_stream.
`timescale 1ns / 1ps

// One result item as seen on the output channel.
typedef struct {
    logic signed [31:0] result;
    logic [2:0]         filter_num;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic               last;
} conv_result_t;

// Shadow copy of the filter store, line store and window, plus a queue of
// the results that the accepted pixels are still owed.
class conv_scoreboard;
    localparam int DIM  = 28;
    localparam int FDIM = 5;
    localparam int NFLT = 8;
    localparam int NWTS = NFLT * FDIM * FDIM;

    logic signed [15:0] weights [NWTS];
    logic signed [15:0] biases [NFLT];
    logic signed [15:0] lines [FDIM-1][DIM];
    logic signed [15:0] window [FDIM][FDIM];
    int                 pix_row;
    int                 pix_col;
    logic [3:0]         frac_shift;
    logic               relu_on;
    conv_result_t       owed_q[$];
    int                 errors;

    function new();
        foreach (weights[i]) weights[i] = '0;
        foreach (biases[i]) biases[i] = '0;
        foreach (lines[i, j]) lines[i][j] = '0;
        foreach (window[i, j]) window[i][j] = '0;
        pix_row = 0;
        pix_col = 0;
        frac_shift = cbr_pkg::FRAC_SHIFT_RST;
        relu_on = cbr_pkg::RELU_ENABLE_RST;
        errors = 0;
    endfunction

    function void note_input(logic [1:0] kind, logic [7:0] index, logic signed [15:0] value);
        logic signed [15:0] column [FDIM];
        longint             sum;
        longint             acc;
        conv_result_t       res;
        if (kind == cbr_pkg::KIND_WEIGHT) begin
            if (index < NWTS) weights[index] = value;
            return;
        end
        if (kind == cbr_pkg::KIND_BIAS) begin
            if (index < NFLT) biases[index] = value;
            return;
        end
        if (kind != cbr_pkg::KIND_PIXEL) return;

        // The new window column is the old line store column over the new pixel.
        for (int i = 0; i < FDIM - 1; i++) column[i] = lines[i][pix_col];
        column[FDIM-1] = value;
        for (int i = 0; i < FDIM - 2; i++) lines[i][pix_col] = lines[i+1][pix_col];
        lines[FDIM-2][pix_col] = value;
        for (int i = 0; i < FDIM; i++)
        begin
            for (int j = 0; j < FDIM - 1; j++) window[i][j] = window[i][j+1];
            window[i][FDIM-1] = column[i];
        end

        if (pix_row >= FDIM - 1 && pix_col >= FDIM - 1)
        begin
            for (int f = 0; f < NFLT; f++)
            begin
                sum = 0;
                for (int i = 0; i < FDIM; i++)
                    for (int j = 0; j < FDIM; j++)
                        sum += longint'(window[i][j]) *
                               longint'(weights[f*FDIM*FDIM + i*FDIM + j]);
                acc = (sum + (longint'(biases[f]) <<< frac_shift)) >>> frac_shift;
                if (relu_on && acc < 0) acc = 0;
                if (acc > 64'sd2147483647) res.result = 32'h7fffffff;
                else if (acc < -64'sd2147483648) res.result = 32'h80000000;
                else res.result = acc[31:0];
                res.filter_num = 3'(f);
                res.out_row = 5'(pix_row - (FDIM - 1));
                res.out_col = 5'(pix_col - (FDIM - 1));
                res.last = (f == NFLT - 1);
                owed_q.push_back(res);
            end
        end

        if (pix_col == DIM - 1)
        begin
            pix_col = 0;
            pix_row = (pix_row == DIM - 1) ? 0 : pix_row + 1;
        end
        else
            pix_col++;
    endfunction

    function void check_result(conv_result_t got);
        conv_result_t exp_r;
        if (owed_q.size() == 0)
        begin
            $error("result item with none expected: result %0d", got.result);
            errors++;
            return;
        end
        exp_r = owed_q.pop_front();
        if (got.result !== exp_r.result)
        begin
            $error("result: expected %0d, got %0d", exp_r.result, got.result);
            errors++;
        end
        if (got.filter_num !== exp_r.filter_num)
        begin
            $error("filter_num: expected %0d, got %0d", exp_r.filter_num, got.filter_num);
            errors++;
        end
        if (got.out_row !== exp_r.out_row)
        begin
            $error("out_row: expected %0d, got %0d", exp_r.out_row, got.out_row);
            errors++;
        end
        if (got.out_col !== exp_r.out_col)
        begin
            $error("out_col: expected %0d, got %0d", exp_r.out_col, got.out_col);
            errors++;
        end
        if (got.last !== exp_r.last)
        begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last);
            errors++;
        end
    endfunction
endclass

module conv2d_bias_relu_stream_tb;
    import cbr_pkg::*;

    // A window pixel runs the single multiplier over every tap of every
    // filter, so this is the longest quiet stretch.
    localparam int DRAIN_CYCLES = 260;
    localparam int CYCLE_LIMIT  = 3000000;

    // The one kind code that the block ignores.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result;
    logic [2:0]         filter_num;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic               last;
    logic               cfg_we;
    logic               cfg_addr;
    logic [3:0]         cfg_wdata;

    // Percentages of cycles in which the sender holds back and the
    // receiver stalls; each phase of the run sets its own pair.
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycle_count;

    conv_scoreboard     sb = new();

    conv2d_bias_relu_stream DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result),
        .filter_num (filter_num),
        .out_row    (out_row),
        .out_col    (out_col),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The receiver decides its stall at each falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both channels are observed at the rising edge, where a handshake
    // completes; the scoreboard sees items in the order they are taken.
    always @(posedge clk)
    begin
        conv_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_input(kind, index, value);
            if (out_valid && !out_stall)
            begin
                got.result = result;
                got.filter_num = filter_num;
                got.out_row = out_row;
                got.out_col = out_col;
                got.last = last;
                sb.check_result(got);
            end
        end
    end

    // A hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[conv2d_bias_relu_stream] ERROR");
            $finish;
        end
    end

    // Offers one item, idling first at random, and returns once it is taken.
    // Valid stays high afterwards so back-to-back items keep it up.
    task automatic send_item(input logic [1:0] k, input logic [7:0] idx,
                             input logic signed [15:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        index <= idx;
        value <= v;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits until every owed result has come, then lets a pixel that owes
    // nothing finish its work too.
    task automatic drain();
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic addr, input logic [3:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_FRAC_SHIFT) sb.frac_shift = data;
        else sb.relu_on = data[0];
    endtask

    // Values lean on the two extremes so that saturation is reached often.
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly pixels; some reloads of the filter store, which the block
    // takes mid-frame, and some items it must ignore.
    task automatic send_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 84) send_item(KIND_PIXEL, 8'($urandom), pick_value());
            else if (pick < 91)
                send_item(KIND_WEIGHT, 8'($urandom_range(199)), pick_value());
            else if (pick < 94)
                send_item(KIND_BIAS, 8'($urandom_range(7)), pick_value());
            else if (pick < 96)
                send_item(KIND_WEIGHT, 8'($urandom_range(255, 200)), 16'($urandom));
            else if (pick < 98)
                send_item(KIND_BIAS, 8'($urandom_range(255, 8)), 16'($urandom));
            else send_item(KIND_UNUSED, 8'($urandom), 16'($urandom));
        end
        stop_sending();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_WEIGHT;
        index = '0;
        value = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_FRAC_SHIFT;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With no fraction bits and no clamp, full-scale kernels saturate
        // both ways.
        write_config(CFG_FRAC_SHIFT, 4'd0);
        write_config(CFG_RELU_ENABLE, 1'b0);

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct = 32;
        recv_stall_pct = 67;

        // Fill the whole filter store while the first rows stream in, so
        // the store is complete before any window can form: filter 0 at the
        // positive extreme, filter 1 at the negative one, the rest random.
        for (int w = 0; w < 200; w++)
        begin
            if (w < 25) send_item(KIND_WEIGHT, 8'(w), 16'sh7fff);
            else if (w < 50) send_item(KIND_WEIGHT, 8'(w), 16'sh8000);
            else send_item(KIND_WEIGHT, 8'(w), 16'($urandom));
            if (w < 112) send_item(KIND_PIXEL, 8'($urandom), pick_value());
        end
        send_item(KIND_BIAS, 8'd0, 16'sh7fff);
        send_item(KIND_BIAS, 8'd1, 16'sh8000);
        for (int f = 2; f < 8; f++) send_item(KIND_BIAS, 8'(f), 16'($urandom));

        // Loads that must be ignored: out-of-range indexes and the unused kind.
        send_item(KIND_WEIGHT, 8'd200, 16'sh1234);
        send_item(KIND_WEIGHT, 8'd255, 16'sh8000);
        send_item(KIND_BIAS, 8'd8, 16'sh7fff);
        send_item(KIND_BIAS, 8'd255, 16'shffff);
        send_item(KIND_UNUSED, 8'd255, 16'sh7fff);

        // Pixels at the field extremes; the index is ignored for them.
        // They end the stretch of pixels that form no window, so the next pixel does.
        send_item(KIND_PIXEL, 8'd255, 16'sh7fff);
        send_item(KIND_PIXEL, 8'd0, 16'sh8000);
        send_item(KIND_PIXEL, 8'd170, 16'sh0000);
        send_item(KIND_PIXEL, 8'd85, 16'shffff);
        stop_sending();

        send_random(25);

        // Hold the sender until every owed result has come out.
        drain();
        write_config(CFG_FRAC_SHIFT, 4'd15);
        write_config(CFG_RELU_ENABLE, 1'b1);

        send_idle_pct = 67;
        recv_stall_pct = 32;
        send_random(25);
        drain();
        write_config(CFG_FRAC_SHIFT, 4'd8);
        write_config(CFG_RELU_ENABLE, 1'b0);

        // No idling at all.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(25);

        drain();
        if (sb.errors == 0)
            $display("[conv2d_bias_relu_stream] OK");
        else
            $display("[conv2d_bias_relu_stream] ERROR");
        $finish;
    end
endmodule
